// ===== sv/kaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaf_pkg
// Shared types, constants and helpers for the angle/bias Kalman filter core.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int unsigned CovFracBits = 28;
  localparam int unsigned DtFracBits  = 16;

  localparam int unsigned MulAW  = 36;
  localparam int unsigned MulBW  = 33;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned MulRW  = 48;

  localparam logic [30:0] AngleNoiseReset = 31'd268435;
  localparam logic [30:0] BiasNoiseReset  = 31'd805306;
  localparam logic [30:0] MeasNoiseReset  = 31'd8053064;

  localparam logic [1:0] RegAngleNoise = 2'd0;
  localparam logic [1:0] RegBiasNoise  = 2'd1;
  localparam logic [1:0] RegMeasNoise  = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t StepAngle  = 4'd0;
  localparam step_t StepT      = 4'd1;
  localparam step_t StepP00    = 4'd2;
  localparam step_t StepP11    = 4'd3;
  localparam step_t StepCorrA  = 4'd4;
  localparam step_t StepCorrB  = 4'd5;
  localparam step_t StepCovP10 = 4'd6;
  localparam step_t StepCovP11 = 4'd7;
  localparam step_t StepCovP01 = 4'd8;
  localparam step_t StepCovP00 = 4'd9;

  typedef struct packed {
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
    logic                    cov_scale;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [MulRW-1:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/kalman_angle_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_filter_core
// Two-state angle and gyro-bias Kalman filter on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word: gyro rate, measured angle and interval.
//   m_axis returns one word per sample: filtered angle and bias estimate.
//   cfg carries noise register writes (index, data); cfg_ready_o is always
//   high, and writes are expected only while no sample is in flight.
// Schedule:
//   A sample runs ten multiply steps on the shared multiplier and, when
//   the innovation variance P00 + R is positive, two serial divisions for
//   the gains. s_axis_tready is high only while the core is idle, so no new
//   sample word is taken until the last result has been accepted.
// Reset:
//   Angle, bias and covariance clear to zero; noise registers take defaults.
// Stall:
//   A result holds on m_axis until taken; no new sample enters meanwhile.
// ----------------------------------------------------------------------------
module kalman_angle_filter_core #(
  parameter int unsigned COV_FRAC_BITS = kaf_pkg::CovFracBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,   // gyro_rate, measured_angle, sample_interval
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // filtered_angle, bias_estimate
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_WB    = 6'b000100,
    ST_GAIN  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  kaf_pkg::step_t     step_q, step_d;
  logic               div_sel_q, div_sel_d;

  logic [30:0]        qa_q, qb_q, r_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] k0_q, k1_q, y_q, rate_q, meas_q;
  logic signed [35:0] t_q;
  logic [15:0]        dt_q;

  kaf_pkg::mul_req_t               mreq;
  logic signed [kaf_pkg::MulRW-1:0] mres;
  logic signed [33:0]              s_w;
  logic                            s_pos;
  logic                            div_start, div_done;
  logic signed [31:0]              div_num, div_quo;
  logic signed [32:0]              dt_s;

  kaf_mul #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .res_o (mres)
  );

  kaf_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (s_w[32:0]),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {bias_q, ang_q};
  assign cfg_ready_o   = 1'b1;

  assign dt_s  = $signed({17'd0, dt_q});
  assign s_w   = 34'(p00_q) + $signed({3'b000, r_q});
  assign s_pos = !s_w[33] && (s_w != 34'sd0);

  always_comb begin
    mreq.a         = '0;
    mreq.b         = dt_s;
    mreq.cov_scale = 1'b1;
    case (step_q)
      kaf_pkg::StepAngle: begin
        mreq.a = 36'(rate_q) - 36'(bias_q);
        mreq.cov_scale = 1'b0;
      end
      kaf_pkg::StepT: begin
        mreq.a = 36'(p11_q);
        mreq.cov_scale = 1'b0;
      end
      kaf_pkg::StepP00: begin
        mreq.a = t_q - 36'(p01_q) - 36'(p10_q) + $signed({5'd0, qa_q});
        mreq.cov_scale = 1'b0;
      end
      kaf_pkg::StepP11: begin
        mreq.a = $signed({5'd0, qb_q});
        mreq.cov_scale = 1'b0;
      end
      kaf_pkg::StepCorrA: begin
        mreq.a = 36'(k0_q);
        mreq.b = 33'(y_q);
      end
      kaf_pkg::StepCorrB: begin
        mreq.a = 36'(k1_q);
        mreq.b = 33'(y_q);
      end
      kaf_pkg::StepCovP10: begin
        mreq.a = 36'(k1_q);
        mreq.b = 33'(p00_q);
      end
      kaf_pkg::StepCovP11: begin
        mreq.a = 36'(k1_q);
        mreq.b = 33'(p01_q);
      end
      kaf_pkg::StepCovP01: begin
        mreq.a = 36'(k0_q);
        mreq.b = 33'(p01_q);
      end
      kaf_pkg::StepCovP00: begin
        mreq.a = 36'(k0_q);
        mreq.b = 33'(p00_q);
      end
      default: begin
        mreq.a = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    div_sel_d = div_sel_q;
    div_start = 1'b0;
    div_num   = p00_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_ISSUE;
          step_d  = kaf_pkg::StepAngle;
        end
      end
      ST_ISSUE: state_d = ST_WB;
      ST_WB: begin
        if (step_q == kaf_pkg::StepP11) begin
          state_d = ST_GAIN;
        end else if (step_q == kaf_pkg::StepCovP00) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_ISSUE;
          step_d  = step_q + kaf_pkg::step_t'(1);
        end
      end
      ST_GAIN: begin
        step_d = kaf_pkg::StepCorrA;
        if (s_pos) begin
          div_start = 1'b1;
          div_sel_d = 1'b0;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_ISSUE;
        end
      end
      ST_DIV: begin
        div_num = p10_q;
        if (div_done) begin
          if (!div_sel_q) begin
            div_start = 1'b1;
            div_sel_d = 1'b1;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= kaf_pkg::StepAngle;
      div_sel_q <= 1'b0;
      qa_q      <= kaf_pkg::AngleNoiseReset;
      qb_q      <= kaf_pkg::BiasNoiseReset;
      r_q       <= kaf_pkg::MeasNoiseReset;
      ang_q     <= '0;
      bias_q    <= '0;
      p00_q     <= '0;
      p01_q     <= '0;
      p10_q     <= '0;
      p11_q     <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      div_sel_q <= div_sel_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kaf_pkg::RegAngleNoise: qa_q <= cfg_data_i[30:0];
          kaf_pkg::RegBiasNoise:  qb_q <= cfg_data_i[30:0];
          kaf_pkg::RegMeasNoise:  r_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (state_q == ST_WB) begin
        case (step_q)
          kaf_pkg::StepAngle:  ang_q <= kaf_pkg::sat32(48'(ang_q) + mres);
          kaf_pkg::StepP00: begin
            p00_q <= kaf_pkg::sat32(48'(p00_q) + mres);
            p01_q <= kaf_pkg::sat32(48'(p01_q) - 48'(t_q));
            p10_q <= kaf_pkg::sat32(48'(p10_q) - 48'(t_q));
          end
          kaf_pkg::StepP11:    p11_q  <= kaf_pkg::sat32(48'(p11_q) + mres);
          kaf_pkg::StepCorrA:  ang_q  <= kaf_pkg::sat32(48'(ang_q) + mres);
          kaf_pkg::StepCorrB:  bias_q <= kaf_pkg::sat32(48'(bias_q) + mres);
          kaf_pkg::StepCovP10: p10_q  <= kaf_pkg::sat32(48'(p10_q) - mres);
          kaf_pkg::StepCovP11: p11_q  <= kaf_pkg::sat32(48'(p11_q) - mres);
          kaf_pkg::StepCovP01: p01_q  <= kaf_pkg::sat32(48'(p01_q) - mres);
          kaf_pkg::StepCovP00: p00_q  <= kaf_pkg::sat32(48'(p00_q) - mres);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      rate_q <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
      dt_q   <= s_axis_tdata[79:64];
    end
    if (state_q == ST_WB && step_q == kaf_pkg::StepT) begin
      t_q <= mres[35:0];
    end
    if (state_q == ST_GAIN) begin
      y_q <= kaf_pkg::sat32(48'(meas_q) - 48'(ang_q));
      if (!s_pos) begin
        k0_q <= '0;
        k1_q <= '0;
      end
    end
    if (state_q == ST_DIV && div_done) begin
      if (!div_sel_q) k0_q <= div_quo;
      else k1_q <= div_quo;
    end
  end

endmodule
`default_nettype wire

// ===== sv/kaf_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaf_mul
// Shared signed multiplier with registered product and round-half-up shift.
// ----------------------------------------------------------------------------
module kaf_mul #(
  parameter int unsigned COV_FRAC_BITS = kaf_pkg::CovFracBits
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  kaf_pkg::mul_req_t                    req_i,
  output logic signed [kaf_pkg::MulRW-1:0]     res_o
);

  logic signed [kaf_pkg::MulPW-1:0] prod_q;
  logic                             cov_q;
  logic signed [kaf_pkg::MulPW:0]   sum;
  logic signed [kaf_pkg::MulPW:0]   shf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q <= 1'b0;
    end else begin
      cov_q <= req_i.cov_scale;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= kaf_pkg::MulPW'(req_i.a) * kaf_pkg::MulPW'(req_i.b);
  end

  always_comb begin
    if (cov_q) begin
      sum = (kaf_pkg::MulPW + 1)'(prod_q) +
            ((kaf_pkg::MulPW + 1)'(1) <<< (COV_FRAC_BITS - 1));
      shf = sum >>> COV_FRAC_BITS;
    end else begin
      sum = (kaf_pkg::MulPW + 1)'(prod_q) +
            ((kaf_pkg::MulPW + 1)'(1) <<< (kaf_pkg::DtFracBits - 1));
      shf = sum >>> kaf_pkg::DtFracBits;
    end
    res_o = shf[kaf_pkg::MulRW-1:0];
  end

endmodule
`default_nettype wire

// ===== sv/kaf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaf_div
// Serial restoring divider for the gains, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kaf_div #(
  parameter int unsigned COV_FRAC_BITS = kaf_pkg::CovFracBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire signed [31:0]  num_i,
  input  wire        [32:0]  den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int unsigned NW = 32 + COV_FRAC_BITS;
  localparam int unsigned DW = 33;
  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0] num_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic          neg_q;
  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic [32:0]   mag;

  assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign mag    = num_i[31] ? (33'd0 - {num_i[31], num_i}) : {1'b0, num_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag[31:0], {COV_FRAC_BITS{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (!diff[DW+1]) begin
        rem_q <= diff[DW:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      if ((|quo_q[NW-1:32]) || (quo_q[31] && (|quo_q[30:0]))) quo_o = -32'sh8000_0000;
      else quo_o = 32'(32'd0 - quo_q[31:0]);
    end else begin
      if (|quo_q[NW-1:31]) quo_o = 32'sh7FFF_FFFF;
      else quo_o = quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== sv/kalman_angle_filter_core_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_filter_core_chk
// Port-level checks for the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module kalman_angle_filter_core_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("core not busy after accepting a word");

  a_idle_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready && !m_axis_tvalid)
    else $error("core not idle after result taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind kalman_angle_filter_core kalman_angle_filter_core_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_kalman_angle_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_angle_filter_core
// Self-checking bench for the angle/bias Kalman filter core. A queue-fed
// driver offers sample words, a bit-exact predictor tracks the filter state
// and the noise registers, and a monitor compares every result word in order.
// Noise registers change between phases only, once the core has drained.
// ----------------------------------------------------------------------------
module tb_kalman_angle_filter_core;

  localparam int CovShift = int'(kaf_pkg::CovFracBits);

  typedef struct packed {
    logic [15:0]        dt;
    logic signed [31:0] meas;
    logic signed [31:0] rate;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] bias;
    logic signed [31:0] angle;
  } estimate_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sample_t     sample_q[$];
  estimate_t   estimate_q[$];
  int          errors = 0;
  int          rx_count = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  logic [30:0]        q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle, est_bias;
  logic signed [31:0] cov[4];

  kalman_angle_filter_core uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint mul_rnd(input longint a, input longint b, input int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  task automatic filter_step(input sample_t smp);
    longint rate, meas, dt, p00, p01, p10, p11, t, inner, s, y, k0, k1;
    estimate_t e;
    rate = longint'(smp.rate);
    meas = longint'(smp.meas);
    dt = longint'(smp.dt);
    p00 = longint'(cov[0]);
    p01 = longint'(cov[1]);
    p10 = longint'(cov[2]);
    p11 = longint'(cov[3]);
    k0 = 0;
    k1 = 0;
    est_angle = clamp32(longint'(est_angle) + mul_rnd(dt, rate - longint'(est_bias), 16));
    t = mul_rnd(dt, p11, 16);
    inner = t - p01 - p10 + longint'(q_angle);
    p00 = longint'(clamp32(p00 + mul_rnd(dt, inner, 16)));
    p01 = longint'(clamp32(p01 - t));
    p10 = longint'(clamp32(p10 - t));
    p11 = longint'(clamp32(p11 + mul_rnd(longint'(q_bias), dt, 16)));
    s = p00 + longint'(r_meas);
    if (s > 0) begin
      k0 = longint'(clamp32((p00 * (64'sd1 <<< CovShift)) / s));
      k1 = longint'(clamp32((p10 * (64'sd1 <<< CovShift)) / s));
    end
    y = longint'(clamp32(meas - longint'(est_angle)));
    est_angle = clamp32(longint'(est_angle) + mul_rnd(k0, y, CovShift));
    est_bias = clamp32(longint'(est_bias) + mul_rnd(k1, y, CovShift));
    cov[0] = clamp32(p00 - mul_rnd(k0, p00, CovShift));
    cov[1] = clamp32(p01 - mul_rnd(k0, p01, CovShift));
    cov[2] = clamp32(p10 - mul_rnd(k1, p00, CovShift));
    cov[3] = clamp32(p11 - mul_rnd(k1, p01, CovShift));
    e.angle = est_angle;
    e.bias = est_bias;
    estimate_q.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s word %0d: got %h want %h", what, rx_count, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t nxt;
    logic    vld;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      vld = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        filter_step(sample_t'(s_axis_tdata));
        vld = 1'b0;
      end
      if (!vld && sample_q.size() > 0 && (no_idle || $urandom_range(99) >= 25)) begin
        nxt = sample_q.pop_front();
        s_axis_tdata <= nxt;
        vld = 1'b1;
      end
      s_axis_tvalid <= vld;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t want;
    estimate_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = estimate_t'(m_axis_tdata);
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected", got.angle, 32'h0);
        end else begin
          want = estimate_q.pop_front();
          if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
          if (got.bias !== want.bias) report_mismatch("bias", got.bias, want.bias);
        end
        rx_count++;
        if (rx_count == 300) hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || $urandom_range(99) >= 25;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[kalman_angle_filter_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      kaf_pkg::RegAngleNoise: q_angle = data[30:0];
      kaf_pkg::RegBiasNoise:  q_bias = data[30:0];
      kaf_pkg::RegMeasNoise:  r_meas = data[30:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (sample_q.size() == 0);
    do @(posedge clk_i); while (s_axis_tvalid || estimate_q.size() != 0);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1 << 20);
      2: return $urandom_range(1 << 26);
      default: return $urandom_range(1 << 30);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t smp;
    if ($urandom_range(99) < 80) begin
      smp.rate = $signed($urandom_range(1 << 24)) - (1 <<< 23);
      smp.meas = $signed($urandom_range(1 << 24)) - (1 <<< 23);
      smp.dt = 16'($urandom_range(1, 2000));
    end else begin
      smp.rate = $urandom;
      smp.meas = $urandom;
      smp.dt = 16'($urandom_range(1, 65535));
    end
    return smp;
  endfunction

  task automatic push(input logic [31:0] rate, input logic [31:0] meas,
                      input logic [15:0] dt);
    sample_t smp;
    smp.rate = rate;
    smp.meas = meas;
    smp.dt = dt;
    sample_q.push_back(smp);
  endtask

  initial begin
    q_angle = kaf_pkg::AngleNoiseReset;
    q_bias = kaf_pkg::BiasNoiseReset;
    r_meas = kaf_pkg::MeasNoiseReset;
    est_angle = '0;
    est_bias = '0;
    for (int i = 0; i < 4; i++) cov[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    push(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    push(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    push(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    push(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
    push(32'h0001_0000, 32'h0000_8000, 16'd0);
    push(32'h0, 32'h0, 16'd0);
    push(32'h0, 32'h0, 16'd655);
    push(32'hFFFF_FFFF, 32'h0000_0001, 16'd65535);
    for (int i = 0; i < 6; i++) push(32'h0000_1000, 32'h0001_0000, 16'd1000);
    drain();

    write_reg(kaf_pkg::RegMeasNoise, 32'h0);
    write_reg(kaf_pkg::RegAngleNoise, 32'h7FFF_FFFF);
    write_reg(kaf_pkg::RegBiasNoise, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'h1234_5678);
    push(32'h0, 32'h0100_0000, 16'hFFFF);
    push(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    push(32'h1234_5678, 32'h0, 16'd1);
    for (int i = 0; i < 5; i++) push($urandom, $urandom, 16'($urandom_range(1, 65535)));
    drain();

    write_reg(kaf_pkg::RegMeasNoise, 32'h7FFF_FFFF);
    write_reg(kaf_pkg::RegAngleNoise, 32'h0);
    write_reg(kaf_pkg::RegBiasNoise, 32'h0);
    for (int i = 0; i < 4; i++) push($urandom, $urandom, 16'($urandom_range(1, 65535)));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(kaf_pkg::RegAngleNoise, {1'b0, kaf_pkg::AngleNoiseReset});
        write_reg(kaf_pkg::RegBiasNoise, {1'b0, kaf_pkg::BiasNoiseReset});
        write_reg(kaf_pkg::RegMeasNoise, {1'b0, kaf_pkg::MeasNoiseReset});
      end else begin
        write_reg(kaf_pkg::RegAngleNoise, rand_noise());
        write_reg(kaf_pkg::RegBiasNoise, rand_noise());
        write_reg(kaf_pkg::RegMeasNoise, ph == 4 ? 32'd1 : rand_noise());
      end
      no_idle = (ph == 2);
      for (int i = 0; i < 205; i++) sample_q.push_back(rand_sample());
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("[kalman_angle_filter_core] OK");
    else $display("[kalman_angle_filter_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/kaf_pkg.sv
sv/kaf_mul.sv
sv/kaf_div.sv
sv/kalman_angle_filter_core.sv
sv/kalman_angle_filter_core_chk.sv
tb/sv/tb_kalman_angle_filter_core.sv
